FILE: sv/mlbs_pkg.sv
// ----------------------------------------------------------------------------
// Morse LED blink sequencer package
// Shared constants, types and the Morse code table for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package mlbs_pkg;

   // Key queue geometry
   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int KEY_W     = 8;
   localparam int TICK_W    = 16;
   localparam int PEND_W    = 4;
   localparam int CSR_IDX_W = 2;
   localparam int BITS_W    = 5;
   localparam int LEFT_W    = 3;

   // Configuration register indices
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DOT_TICKS        = 2'd0,
      CSR_DASH_TICKS       = 2'd1,
      CSR_SYMBOL_GAP_TICKS = 2'd2,
      CSR_LETTER_GAP_TICKS = 2'd3
   } csr_index_type;

   // Register reset values
   localparam logic [TICK_W-1:0] DOT_TICKS_RST        = 16'd200;
   localparam logic [TICK_W-1:0] DASH_TICKS_RST       = 16'd600;
   localparam logic [TICK_W-1:0] SYMBOL_GAP_TICKS_RST = 16'd200;
   localparam logic [TICK_W-1:0] LETTER_GAP_TICKS_RST = 16'd800;

   // Input command codes
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   // One row of the Morse table: symbol count less one, and the symbols with
   // the first one in bit 0 (1 = dash).
   typedef struct packed {
      logic              hit;
      logic [LEFT_W-1:0] left;
      logic [BITS_W-1:0] pattern;
   } morse_code_type;

   // Key queue status towards the blink engine
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               full;
      logic               empty;
   } fifo_status_type;

   // Blink engine status towards the result register
   typedef struct packed {
      logic led_on;
      logic busy;
   } blink_status_type;

   // Fixed table: digits, A to D, '*' as a dot and '#' as a dash.
   function automatic morse_code_type morse_lookup(input logic [KEY_W-1:0] key);
      morse_code_type code;
      code = '{hit: 1'b1, left: '0, pattern: '0};
      unique case (key)
         8'h30:   begin code.left = 3'd4; code.pattern = 5'h1F; end // '0'
         8'h31:   begin code.left = 3'd4; code.pattern = 5'h1E; end // '1'
         8'h32:   begin code.left = 3'd4; code.pattern = 5'h1C; end // '2'
         8'h33:   begin code.left = 3'd4; code.pattern = 5'h18; end // '3'
         8'h34:   begin code.left = 3'd4; code.pattern = 5'h10; end // '4'
         8'h35:   begin code.left = 3'd4; code.pattern = 5'h00; end // '5'
         8'h36:   begin code.left = 3'd4; code.pattern = 5'h01; end // '6'
         8'h37:   begin code.left = 3'd4; code.pattern = 5'h03; end // '7'
         8'h38:   begin code.left = 3'd4; code.pattern = 5'h07; end // '8'
         8'h39:   begin code.left = 3'd4; code.pattern = 5'h0F; end // '9'
         8'h41:   begin code.left = 3'd1; code.pattern = 5'h02; end // 'A'
         8'h42:   begin code.left = 3'd3; code.pattern = 5'h01; end // 'B'
         8'h43:   begin code.left = 3'd3; code.pattern = 5'h05; end // 'C'
         8'h44:   begin code.left = 3'd2; code.pattern = 5'h01; end // 'D'
         8'h2A:   begin code.left = 3'd0; code.pattern = 5'h00; end // '*'
         8'h23:   begin code.left = 3'd0; code.pattern = 5'h01; end // '#'
         default: begin code.hit  = 1'b0; end
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

FILE: sv/morse_led_blink_sequencer.sv
// ----------------------------------------------------------------------------
// Morse LED blink sequencer
// Queues key codes and blinks each one in Morse code on millisecond ticks.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req_    | in        | tuser = command, tdata = key_code
//  rsp_    | out       | tdata = led_on, busy_res, key_refused, pending_count
//  csr_    | in        | write enable, register index, 16-bit data
//
// Each transaction is registered in the input register, processed
// combinationally and its result held in the output register, so one request
// per cycle is sustained while responses are taken. The input register is
// refilled while a response waits as long as the output register can move.
// A stalled response holds both registers. Reset is synchronous and needs no
// clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_led_blink_sequencer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [7:0]                     req_tdata,  // [7:0] key_code
   input  wire logic                           req_tuser,  // [0] command
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [7:0]                          rsp_tdata,  // [0] led_on, [1] busy_res,
                                                           // [2] key_refused,
                                                           // [6:3] pending_count, [7] zero
   input  wire logic                           csr_we,
   input  wire logic [mlbs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mlbs_pkg::TICK_W-1:0]    csr_wdata
);
   import mlbs_pkg::*;

   logic              in_valid_ff;
   logic              in_cmd_ff;
   logic [KEY_W-1:0]  in_key_ff;
   logic              out_valid_ff;
   logic [7:0]        out_data_ff;
   logic              advance;
   logic              push;
   logic              tick;
   logic              pop;
   logic [KEY_W-1:0]  head_key;
   logic              refused;
   logic [PEND_W-1:0] pending_next;
   logic [TICK_W-1:0] dot_ff, dash_ff, sym_gap_ff, let_gap_ff;
   fifo_status_type   fifo_status;
   blink_status_type  blink_status;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff     <= DOT_TICKS_RST;
         dash_ff    <= DASH_TICKS_RST;
         sym_gap_ff <= SYMBOL_GAP_TICKS_RST;
         let_gap_ff <= LETTER_GAP_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DOT_TICKS:        dot_ff     <= csr_wdata;
            CSR_DASH_TICKS:       dash_ff    <= csr_wdata;
            CSR_SYMBOL_GAP_TICKS: sym_gap_ff <= csr_wdata;
            CSR_LETTER_GAP_TICKS: let_gap_ff <= csr_wdata;
         endcase
      end
   end

   // Handshake: the stage moves when the output register is free or draining.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign push       = advance && (in_cmd_ff == CMD_ENQUEUE);
   assign tick       = advance && (in_cmd_ff == CMD_TICK);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff <= req_tuser;
         in_key_ff <= req_tdata;
      end
   end

   mlbs_key_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_key (in_key_ff),
      .pop      (pop),
      .head_key (head_key),
      .status   (fifo_status)
   );

   mlbs_blink_fsm u_blink (
      .clock            (clock),
      .reset            (reset),
      .tick             (tick),
      .head_key         (head_key),
      .queue_empty      (fifo_status.empty),
      .dot_ticks        (dot_ff),
      .dash_ticks       (dash_ff),
      .symbol_gap_ticks (sym_gap_ff),
      .letter_gap_ticks (let_gap_ff),
      .pop              (pop),
      .status_next      (blink_status)
   );

   // Fill count after this transaction
   always_comb begin
      refused = push && fifo_status.full;
      if (push && !fifo_status.full) begin
         pending_next = PEND_W'(fifo_status.count + COUNT_W'(1));
      end else if (pop) begin
         pending_next = PEND_W'(fifo_status.count - COUNT_W'(1));
      end else begin
         pending_next = PEND_W'(fifo_status.count);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= {1'b0, pending_next, refused, blink_status.busy,
                         blink_status.led_on};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

FILE: sv/mlbs_key_fifo.sv
// ----------------------------------------------------------------------------
// Morse LED blink sequencer key queue
// Circular store of pending key codes with read pointer and fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module mlbs_key_fifo (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire logic [mlbs_pkg::KEY_W-1:0]  push_key,
   input  wire logic                        pop,
   output logic [mlbs_pkg::KEY_W-1:0]       head_key,
   output mlbs_pkg::fifo_status_type        status
);
   import mlbs_pkg::*;

   localparam int SUM_W = PTR_W + 1;

   logic [KEY_W-1:0]   store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   wr_sum;
   logic [PTR_W-1:0]   wr_idx;
   logic               full;
   logic               empty;

   // Status and head of the queue
   assign full     = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_key = store_ff[rd_ptr_ff];
   assign status   = '{count: count_ff, full: full, empty: empty};

   // Write slot is the read pointer plus the fill count, wrapped once.
   assign wr_sum = {1'b0, rd_ptr_ff} + SUM_W'(count_ff);
   assign wr_idx = (wr_sum >= SUM_W'(QUEUE_DEPTH)) ?
                   PTR_W'(wr_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(wr_sum);

   // Pointer and count update; a push and a pop never come together.
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !empty) begin
         count_in  = count_ff - COUNT_W'(1);
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Key store, no reset
   always_ff @(posedge clock) begin
      if (push && !full) begin
         store_ff[wr_idx] <= push_key;
      end
   end

endmodule

`default_nettype wire

FILE: sv/mlbs_blink_fsm.sv
// ----------------------------------------------------------------------------
// Morse LED blink sequencer blink engine
// Phase machine that times dots, dashes and gaps on tick transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module mlbs_blink_fsm (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         tick,
   input  wire logic [mlbs_pkg::KEY_W-1:0]   head_key,
   input  wire logic                         queue_empty,
   input  wire logic [mlbs_pkg::TICK_W-1:0]  dot_ticks,
   input  wire logic [mlbs_pkg::TICK_W-1:0]  dash_ticks,
   input  wire logic [mlbs_pkg::TICK_W-1:0]  symbol_gap_ticks,
   input  wire logic [mlbs_pkg::TICK_W-1:0]  letter_gap_ticks,
   output logic                              pop,
   output mlbs_pkg::blink_status_type        status_next
);
   import mlbs_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_ON     = 2'd1,
      PH_GAP    = 2'd2,
      PH_LETTER = 2'd3
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [TICK_W-1:0] countdown_ff, countdown_in;
   logic              led_ff, led_in;
   morse_code_type    code;

   assign code = morse_lookup(head_key);

   // Next phase on a tick transaction
   always_comb begin
      phase_in     = phase_ff;
      bits_in      = bits_ff;
      left_in      = left_ff;
      countdown_in = countdown_ff;
      led_in       = led_ff;
      pop          = 1'b0;
      if (tick) begin
         if (phase_ff == PH_IDLE) begin
            // Take one key; an unknown key is dropped and the engine stays idle.
            if (!queue_empty) begin
               pop = 1'b1;
               if (code.hit) begin
                  left_in      = code.left;
                  countdown_in = code.pattern[0] ? dash_ticks : dot_ticks;
                  bits_in      = {1'b0, code.pattern[BITS_W-1:1]};
                  phase_in     = PH_ON;
                  led_in       = 1'b1;
               end
            end
         end else if (countdown_ff > TICK_W'(1)) begin
            countdown_in = countdown_ff - TICK_W'(1);
         end else begin
            unique case (phase_ff)
               PH_ON: begin
                  led_in       = 1'b0;
                  phase_in     = PH_GAP;
                  countdown_in = symbol_gap_ticks;
               end
               PH_GAP: begin
                  if (left_ff != '0) begin
                     left_in      = left_ff - LEFT_W'(1);
                     countdown_in = bits_ff[0] ? dash_ticks : dot_ticks;
                     bits_in      = {1'b0, bits_ff[BITS_W-1:1]};
                     phase_in     = PH_ON;
                     led_in       = 1'b1;
                  end else begin
                     phase_in     = PH_LETTER;
                     countdown_in = letter_gap_ticks;
                  end
               end
               PH_LETTER: begin
                  phase_in     = PH_IDLE;
                  countdown_in = '0;
                  bits_in      = '0;
               end
               PH_IDLE: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // Status as it stands after this transaction
   assign status_next = '{led_on: led_in, busy: (phase_in != PH_IDLE)};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bits_ff      <= '0;
         left_ff      <= '0;
         countdown_ff <= '0;
         led_ff       <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bits_ff      <= bits_in;
         left_ff      <= left_in;
         countdown_ff <= countdown_in;
         led_ff       <= led_in;
      end
   end

endmodule

`default_nettype wire

FILE: dv/tb_morse_led_blink_sequencer.sv
// ----------------------------------------------------------------------------
// Testbench for the Morse LED blink sequencer
// Streams key codes and ticks into the sequencer under several timing
// settings. A scoreboard predicts the LED and queue status of every
// transaction and checks each response, field by field, in order.
// ----------------------------------------------------------------------------
import mlbs_pkg::*;

// Status reported for one transaction, laid out as rsp_tdata
typedef struct packed {
   logic              pad;
   logic [PEND_W-1:0] pending;
   logic              refused;
   logic              busy;
   logic              led_on;
} led_status_type;

typedef enum logic [1:0] {
   BLINK_IDLE,
   BLINK_LIT,
   BLINK_SPACE,
   BLINK_LETTER
} blink_phase_type;

class keyer_scoreboard;
   // Timing registers as last written
   logic [TICK_W-1:0] dot_ticks, dash_ticks, gap_ticks, letter_ticks;
   // Own copy of the key queue and blink engine
   logic [KEY_W-1:0]  keys [QUEUE_DEPTH];
   int unsigned       rd_ptr, fill;
   blink_phase_type   phase;
   logic [BITS_W-1:0] sym_bits;
   logic [LEFT_W-1:0] sym_left;
   logic [TICK_W-1:0] count_down;
   logic              led;
   // Statuses still owed by the sequencer, oldest first
   led_status_type    status_due[$];
   int unsigned       errors, requests, checked, lit_seen, refusals;

   function new();
      dot_ticks    = DOT_TICKS_RST;
      dash_ticks   = DASH_TICKS_RST;
      gap_ticks    = SYMBOL_GAP_TICKS_RST;
      letter_ticks = LETTER_GAP_TICKS_RST;
      rd_ptr       = 0;
      fill         = 0;
      phase        = BLINK_IDLE;
      sym_bits     = '0;
      sym_left     = '0;
      count_down   = '0;
      led          = 1'b0;
   endfunction

   function void set_timing(csr_index_type idx, logic [TICK_W-1:0] value);
      case (idx)
         CSR_DOT_TICKS:        dot_ticks    = value;
         CSR_DASH_TICKS:       dash_ticks   = value;
         CSR_SYMBOL_GAP_TICKS: gap_ticks    = value;
         CSR_LETTER_GAP_TICKS: letter_ticks = value;
      endcase
   endfunction

   // Dots and dashes of a key, first symbol leftmost; empty if not in the code.
   function string morse_of(logic [KEY_W-1:0] key);
      case (key)
         "0": return "-----";
         "1": return ".----";
         "2": return "..---";
         "3": return "...--";
         "4": return "....-";
         "5": return ".....";
         "6": return "-....";
         "7": return "--...";
         "8": return "---..";
         "9": return "----.";
         "A": return ".-";
         "B": return "-...";
         "C": return "-.-.";
         "D": return "-..";
         "*": return ".";
         "#": return "-";
         default: return "";
      endcase
   endfunction

   // Start the symbol in bit 0 and shift it out.
   function void light_symbol();
      count_down = sym_bits[0] ? dash_ticks : dot_ticks;
      sym_bits   = sym_bits >> 1;
      phase      = BLINK_LIT;
      led        = 1'b1;
   endfunction

   function void tick_keyer();
      string code;
      byte   dash;
      dash = "-";
      if (phase == BLINK_IDLE) begin
         // Pop one key; an unknown key is simply dropped.
         if (fill > 0) begin
            code   = morse_of(keys[rd_ptr]);
            rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
            fill--;
            if (code.len() > 0) begin
               sym_bits = '0;
               for (int i = 0; i < code.len(); i++) sym_bits[i] = (code[i] == dash);
               sym_left = LEFT_W'(code.len() - 1);
               light_symbol();
            end
         end
         return;
      end
      if (count_down > 1) begin
         count_down--;
         return;
      end
      case (phase)
         BLINK_LIT: begin
            led        = 1'b0;
            phase      = BLINK_SPACE;
            count_down = gap_ticks;
         end
         BLINK_SPACE: begin
            if (sym_left > 0) begin
               sym_left--;
               light_symbol();
            end else begin
               phase      = BLINK_LETTER;
               count_down = letter_ticks;
            end
         end
         default: begin
            phase      = BLINK_IDLE;
            count_down = '0;
            sym_bits   = '0;
         end
      endcase
   endfunction

   // An accepted request: update the model and queue the status it implies.
   function void note_request(logic cmd, logic [KEY_W-1:0] key);
      led_status_type st;
      logic           refused;
      refused = 1'b0;
      requests++;
      if (cmd == CMD_ENQUEUE) begin
         if (fill >= QUEUE_DEPTH) begin
            refused = 1'b1;
            refusals++;
         end else begin
            keys[(rd_ptr + fill) % QUEUE_DEPTH] = key;
            fill++;
         end
      end else begin
         tick_keyer();
      end
      st.pad     = 1'b0;
      st.pending = PEND_W'(fill);
      st.refused = refused;
      st.busy    = (phase != BLINK_IDLE);
      st.led_on  = led;
      status_due.push_back(st);
   endfunction

   function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   // An accepted response: compare it with the oldest prediction.
   function void check_response(logic [7:0] data);
      led_status_type want, got;
      got = data;
      checked++;
      if (got.led_on) lit_seen++;
      if (status_due.size() == 0) begin
         errors++;
         $display("%0t: unexpected response, expected none, actual 0x%02h", $time, data);
         return;
      end
      want = status_due.pop_front();
      compare_field("led_on", want.led_on, got.led_on);
      compare_field("busy_res", want.busy, got.busy);
      compare_field("key_refused", want.refused, got.refused);
      compare_field("pending_count", want.pending, got.pending);
      compare_field("padding bit", want.pad, got.pad);
   endfunction

   function bit drained();
      return status_due.size() == 0;
   endfunction
endclass

module tb_morse_led_blink_sequencer;

   localparam int    CYCLE_LIMIT = 600000;
   localparam string MORSE_KEYS  = "0123456789ABCD*#";

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [KEY_W-1:0]     req_tdata  = '0;
   logic                 req_tuser  = CMD_TICK;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = CSR_DOT_TICKS;
   logic [TICK_W-1:0]    csr_wdata  = '0;

   keyer_scoreboard sb = new();
   bit              tx_idling = 1'b1;
   bit              rx_idling = 1'b1;
   int unsigned     settings_used = 1;
   int unsigned     cycle_count = 0;

   morse_led_blink_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int unsigned gap_len();
      return ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(6, 40);
   endfunction

   // Mostly keys from the code, the rest any byte at all.
   function automatic logic [KEY_W-1:0] random_key();
      if ($urandom_range(99) < 80) return MORSE_KEYS[$urandom_range(0, 15)];
      return KEY_W'($urandom);
   endfunction

   // Offer one transaction and wait for it to be taken.
   task automatic offer_item(input logic cmd, input logic [KEY_W-1:0] key);
      req_tuser  <= cmd;
      req_tdata  <= key;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, key);
      if (tx_idling && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (!sb.drained()) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [TICK_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_timing(idx, value);
   endtask

   // Rewrite all four timing registers; only called with nothing in flight.
   task automatic program_timing(input logic [TICK_W-1:0] dot, input logic [TICK_W-1:0] dash,
                                 input logic [TICK_W-1:0] gap, input logic [TICK_W-1:0] letter);
      csr_write(CSR_DOT_TICKS, dot);
      csr_write(CSR_DASH_TICKS, dash);
      csr_write(CSR_SYMBOL_GAP_TICKS, gap);
      csr_write(CSR_LETTER_GAP_TICKS, letter);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Random mix of ticks and keys, with the odd burst of keys to fill the queue.
   task automatic run_random(input int n, input int tick_pct);
      int done;
      int burst;
      done = 0;
      while (done < n) begin
         if ($urandom_range(99) < 4) begin
            burst = $urandom_range(8, 11);
            repeat (burst) offer_item(CMD_ENQUEUE, random_key());
            done += burst;
         end else if ($urandom_range(99) < tick_pct) begin
            offer_item(CMD_TICK, KEY_W'($urandom));
            done++;
         end else begin
            offer_item(CMD_ENQUEUE, random_key());
            done++;
         end
      end
      req_tvalid <= 1'b0;
      // The sender pauses here until every response is back.
      wait_drained();
   endtask

   // Response side: random back-pressure and one long hold-off mid-run.
   initial begin
      int unsigned hold;
      bit          long_hold_done;
      hold           = 0;
      long_hold_done = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (!long_hold_done && sb.checked >= 700) begin
            long_hold_done = 1'b1;
            hold           = 150;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (rx_idling && $urandom_range(99) < 15) begin
            hold       = gap_len() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILED: results differ");
      $finish;
   end

   // Main sequence
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset timing: fill the queue with edge keys, overflow it, start a dot.
      offer_item(CMD_ENQUEUE, "*");
      offer_item(CMD_ENQUEUE, 8'h00);
      offer_item(CMD_ENQUEUE, 8'hFF);
      offer_item(CMD_ENQUEUE, "A");
      offer_item(CMD_ENQUEUE, "#");
      offer_item(CMD_ENQUEUE, "0");
      offer_item(CMD_ENQUEUE, "5");
      offer_item(CMD_ENQUEUE, "C");
      offer_item(CMD_ENQUEUE, "D");
      offer_item(CMD_TICK, 8'hFF);
      offer_item(CMD_TICK, 8'h00);
      req_tvalid <= 1'b0;
      wait_drained();

      // Shortest timing, zero standing in for one tick.
      program_timing('0, 16'd1, '0, 16'd1);
      offer_item(CMD_ENQUEUE, "9");
      offer_item(CMD_ENQUEUE, "B");
      repeat (12) offer_item(CMD_TICK, KEY_W'($urandom));
      req_tvalid <= 1'b0;
      wait_drained();

      run_random(350, 80);

      program_timing(TICK_W'($urandom_range(1, 4)), TICK_W'($urandom_range(1, 4)),
                     TICK_W'($urandom_range(1, 4)), TICK_W'($urandom_range(1, 4)));
      run_random(300, 75);

      // Back-to-back transactions with no idling, keys arriving often.
      tx_idling = 1'b0;
      rx_idling = 1'b0;
      program_timing(16'd1, 16'd2, 16'd1, 16'd3);
      run_random(250, 50);
      tx_idling = 1'b1;
      rx_idling = 1'b1;

      program_timing(TICK_W'($urandom_range(1, 6)), TICK_W'($urandom_range(1, 6)),
                     TICK_W'($urandom_range(1, 6)), TICK_W'($urandom_range(1, 6)));
      run_random(300, 85);

      program_timing(DOT_TICKS_RST, DASH_TICKS_RST, SYMBOL_GAP_TICKS_RST,
                     LETTER_GAP_TICKS_RST);
      run_random(200, 95);

      // Longest timing last, as it leaves the engine counting for a long time.
      program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random(150, 60);

      repeat (8) @(posedge clock);
      $display("Covered %0d key and tick transactions over %0d timing settings.",
               sb.requests, settings_used);
      $display("Checked %0d responses, %0d with the LED lit, %0d keys refused on a full queue.",
               sb.checked, sb.lit_seen, sb.refusals);
      if (sb.errors == 0 && sb.drained()) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
